>>> src/jfs_pkg.sv
// ----------------------------------------------------------------------------
// jfs_pkg
// Shared codes, types and helpers for the JPEG frame size scanner.
// ----------------------------------------------------------------------------
package jfs_pkg;

  // Parse phase codes
  localparam logic [3:0] PH_START0  = 4'd0;
  localparam logic [3:0] PH_START1  = 4'd1;
  localparam logic [3:0] PH_HUNT    = 4'd2;
  localparam logic [3:0] PH_MARKER  = 4'd3;
  localparam logic [3:0] PH_SOFLEN0 = 4'd4;
  localparam logic [3:0] PH_SOFLEN1 = 4'd5;
  localparam logic [3:0] PH_PREC    = 4'd6;
  localparam logic [3:0] PH_HGT0    = 4'd7;
  localparam logic [3:0] PH_HGT1    = 4'd8;
  localparam logic [3:0] PH_WID0    = 4'd9;
  localparam logic [3:0] PH_WID1    = 4'd10;
  localparam logic [3:0] PH_COMP    = 4'd11;
  localparam logic [3:0] PH_LEN0    = 4'd12;
  localparam logic [3:0] PH_LEN1    = 4'd13;
  localparam logic [3:0] PH_SKIP    = 4'd14;
  localparam logic [3:0] PH_IDLE    = 4'd15;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADSTART = 3'd1;
  localparam logic [2:0] ST_JUNK     = 3'd2;
  localparam logic [2:0] ST_SCANEND  = 3'd3;
  localparam logic [2:0] ST_BADLEN   = 3'd4;
  localparam logic [2:0] ST_EARLY    = 3'd5;

  // Marker bytes
  localparam logic [7:0] MK_FILL = 8'hFF;
  localparam logic [7:0] MK_SOI  = 8'hD8;
  localparam logic [7:0] MK_SOS  = 8'hDA;
  localparam logic [7:0] MK_EOI  = 8'hD9;
  localparam logic [7:0] MK_SOF_LO = 8'hC0;
  localparam logic [7:0] MK_SOF_HI = 8'hCF;
  localparam logic [7:0] MK_DHT  = 8'hC4;
  localparam logic [7:0] MK_JPG  = 8'hC8;
  localparam logic [7:0] MK_DAC  = 8'hCC;

  localparam logic [15:0] MIN_SEG_LEN = 16'd2;

  // Parser state carried from beat to beat
  typedef struct packed {
    logic [3:0]  phase;
    logic        junk_seen;
    logic [15:0] skip_count;
    logic [15:0] height_hold;
    logic [15:0] width_hold;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:       PH_START0,
    junk_seen:   1'b0,
    skip_count:  16'd0,
    height_hold: 16'd0,
    width_hold:  16'd0
  };

  // One result beat
  typedef struct packed {
    logic        fire;
    logic [2:0]  status;
    logic [15:0] height;
    logic [15:0] width;
  } scan_result_t;

  // Start-of-frame codes: C0..CF except DHT, JPG and DAC
  function automatic logic is_frame_marker(input logic [7:0] m);
    logic in_range;
    in_range = (m >= MK_SOF_LO) && (m <= MK_SOF_HI);
    return in_range && (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
  endfunction

endpackage

>>> src/jpeg_frame_size_scanner.sv
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner
// A result is registered and appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle; the parser state updates in a single step.
// A result waiting on out_ready holds off the next byte until it is taken.
// Reset: synchronous; parser goes to expecting the first start byte, no result.
// ----------------------------------------------------------------------------
// Walks JPEG markers byte by byte and reports the first frame size or a
// failure status.
// ----------------------------------------------------------------------------
module jpeg_frame_size_scanner
  import jfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        start_of_file,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] frame_height,
  output logic [15:0] frame_width
);

  parse_state_t state;
  parse_state_t state_next;
  scan_result_t res;
  logic         in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  jfs_step u_step (
    .cur           (state),
    .byte_value    (byte_value),
    .start_of_file (start_of_file),
    .end_of_file   (end_of_file),
    .nxt           (state_next),
    .res           (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PARSE_RESET;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && res.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.fire) begin
      status       <= res.status;
      frame_height <= res.height;
      frame_width  <= res.width;
    end
  end

endmodule

>>> src/jfs_step.sv
// ----------------------------------------------------------------------------
// jfs_step
// Next-state and result logic for one byte of the marker parser.
// ----------------------------------------------------------------------------
module jfs_step
  import jfs_pkg::*;
(
  input  parse_state_t cur,
  input  logic [7:0]   byte_value,
  input  logic         start_of_file,
  input  logic         end_of_file,
  output parse_state_t nxt,
  output scan_result_t res
);

  parse_state_t eff;
  logic [15:0]  seg_len;

  // start flag restarts the parse on this byte
  assign eff     = start_of_file ? PARSE_RESET : cur;
  assign seg_len = {eff.skip_count[7:0], byte_value};

  always_comb begin
    nxt = eff;
    res = '{fire: 1'b0, status: ST_OK, height: 16'd0, width: 16'd0};
    if (eff.phase == PH_IDLE) begin
      // finished; wait for a restart
    end else if (end_of_file) begin
      res.fire   = 1'b1;
      res.status = ST_EARLY;
      nxt.phase  = PH_IDLE;
    end else begin
      unique case (eff.phase)
        PH_START0: begin
          if (byte_value != MK_FILL) begin
            res.fire   = 1'b1;
            res.status = ST_BADSTART;
            nxt.phase  = PH_IDLE;
          end else begin
            nxt.phase = PH_START1;
          end
        end
        PH_START1: begin
          if (byte_value != MK_SOI) begin
            res.fire   = 1'b1;
            res.status = ST_BADSTART;
            nxt.phase  = PH_IDLE;
          end else begin
            nxt.phase     = PH_HUNT;
            nxt.junk_seen = 1'b0;
          end
        end
        PH_HUNT: begin
          if (byte_value == MK_FILL) nxt.phase = PH_MARKER;
          else nxt.junk_seen = 1'b1;
        end
        PH_MARKER: begin
          if (byte_value == MK_FILL) begin
            // fill byte, keep hunting for the code
          end else if (eff.junk_seen) begin
            res.fire   = 1'b1;
            res.status = ST_JUNK;
            nxt.phase  = PH_IDLE;
          end else if (is_frame_marker(byte_value)) begin
            nxt.phase = PH_SOFLEN0;
          end else if (byte_value == MK_SOS || byte_value == MK_EOI) begin
            res.fire   = 1'b1;
            res.status = ST_SCANEND;
            nxt.phase  = PH_IDLE;
          end else begin
            nxt.phase = PH_LEN0;
          end
        end
        PH_SOFLEN0: nxt.phase = PH_SOFLEN1;
        PH_SOFLEN1: nxt.phase = PH_PREC;
        PH_PREC:    nxt.phase = PH_HGT0;
        PH_HGT0: begin
          nxt.height_hold = {byte_value, 8'd0};
          nxt.phase       = PH_HGT1;
        end
        PH_HGT1: begin
          nxt.height_hold = {eff.height_hold[15:8], byte_value};
          nxt.phase       = PH_WID0;
        end
        PH_WID0: begin
          nxt.width_hold = {byte_value, 8'd0};
          nxt.phase      = PH_WID1;
        end
        PH_WID1: begin
          nxt.width_hold = {eff.width_hold[15:8], byte_value};
          nxt.phase      = PH_COMP;
        end
        PH_COMP: begin
          res.fire   = 1'b1;
          res.status = ST_OK;
          res.height = eff.height_hold;
          res.width  = eff.width_hold;
          nxt.phase  = PH_IDLE;
        end
        PH_LEN0: begin
          // high byte of the length held in skip_count
          nxt.skip_count = {8'd0, byte_value};
          nxt.phase      = PH_LEN1;
        end
        PH_LEN1: begin
          if (seg_len < MIN_SEG_LEN) begin
            res.fire   = 1'b1;
            res.status = ST_BADLEN;
            nxt.phase  = PH_IDLE;
          end else begin
            nxt.skip_count = seg_len - MIN_SEG_LEN;
            nxt.junk_seen  = 1'b0;
            nxt.phase      = (seg_len == MIN_SEG_LEN) ? PH_HUNT : PH_SKIP;
          end
        end
        PH_SKIP: begin
          nxt.skip_count = eff.skip_count - 16'd1;
          if (eff.skip_count == 16'd1) begin
            nxt.junk_seen = 1'b0;
            nxt.phase     = PH_HUNT;
          end
        end
        default: nxt.phase = PH_IDLE;
      endcase
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: JPEG frame size scanner testbench
// Sends JPEG-like byte streams: a short hand-written set of files, a long
// marker segment, then random files (mostly well formed, some broken) and raw
// noise. A local parser tracks every accepted beat and queues the status and
// size that the block must report. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import jfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] MK_APP1 = 8'hE1;
  localparam logic [7:0] MK_RST0 = 8'hD0;
  localparam logic [7:0] MK_NUL  = 8'h00;

  typedef enum {FK_GOOD, FK_BAD_START, FK_JUNK, FK_SCAN_END, FK_BAD_LEN} file_kind_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] height;
    logic [15:0] width;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_value = 8'h00;
  logic        start_of_file = 1'b0;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] frame_height;
  logic [15:0] frame_width;

  // Local copy of the parser state
  logic [3:0]  p_phase = PH_START0;
  logic        p_junk = 1'b0;
  logic [15:0] p_skip = '0;
  logic [15:0] p_height = '0;
  logic [15:0] p_width = '0;

  report_t     pending_reports[$];
  logic [7:0]  file_q[$];
  int          parsed_beats = 0;
  int          mismatches = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;

  jpeg_frame_size_scanner uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .byte_value(byte_value), .start_of_file(start_of_file), .end_of_file(end_of_file),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .frame_height(frame_height), .frame_width(frame_width)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end

  // Start-of-frame: high nibble C, except low nibble 4, 8 or C
  function automatic bit sof_code(input logic [7:0] c);
    return (c[7:4] == 4'hC) && !((c[1:0] == 2'b00) && (c[3:2] != 2'b00));
  endfunction

  task automatic finish_parse(input logic [2:0] st, input logic [15:0] h, input logic [15:0] w);
    report_t r;
    r.status = st;
    r.height = h;
    r.width  = w;
    pending_reports.push_back(r);
    p_phase = PH_IDLE;
  endtask

  // Advance the local parser by one accepted beat
  task automatic scan_step(input logic [7:0] b, input bit sof, input bit eof);
    logic [15:0] seg_len;
    if (sof) begin
      p_phase  = PH_START0;
      p_junk   = 1'b0;
      p_skip   = '0;
      p_height = '0;
      p_width  = '0;
    end
    if (p_phase == PH_IDLE) return;
    parsed_beats++;
    if (eof) begin
      finish_parse(ST_EARLY, '0, '0);
      return;
    end
    case (p_phase)
      PH_START0: begin
        if (b != MK_FILL) finish_parse(ST_BADSTART, '0, '0);
        else p_phase = PH_START1;
      end
      PH_START1: begin
        if (b != MK_SOI) finish_parse(ST_BADSTART, '0, '0);
        else begin
          p_phase = PH_HUNT;
          p_junk  = 1'b0;
        end
      end
      PH_HUNT: begin
        if (b == MK_FILL) p_phase = PH_MARKER;
        else p_junk = 1'b1;
      end
      PH_MARKER: begin
        if (b == MK_FILL) begin
          // fill byte, keep waiting for the code
        end else if (p_junk) begin
          finish_parse(ST_JUNK, '0, '0);
        end else if (sof_code(b)) begin
          p_phase = PH_SOFLEN0;
        end else if (b == MK_SOS || b == MK_EOI) begin
          finish_parse(ST_SCANEND, '0, '0);
        end else begin
          p_phase = PH_LEN0;
        end
      end
      PH_SOFLEN0: p_phase = PH_SOFLEN1;
      PH_SOFLEN1: p_phase = PH_PREC;
      PH_PREC:    p_phase = PH_HGT0;
      PH_HGT0: begin
        p_height = {b, 8'h00};
        p_phase  = PH_HGT1;
      end
      PH_HGT1: begin
        p_height[7:0] = b;
        p_phase = PH_WID0;
      end
      PH_WID0: begin
        p_width = {b, 8'h00};
        p_phase = PH_WID1;
      end
      PH_WID1: begin
        p_width[7:0] = b;
        p_phase = PH_COMP;
      end
      PH_COMP: finish_parse(ST_OK, p_height, p_width);
      PH_LEN0: begin
        p_skip  = {b, 8'h00};
        p_phase = PH_LEN1;
      end
      PH_LEN1: begin
        seg_len = {p_skip[15:8], b};
        if (seg_len < MIN_SEG_LEN) begin
          finish_parse(ST_BADLEN, '0, '0);
        end else begin
          p_skip  = seg_len - MIN_SEG_LEN;
          p_junk  = 1'b0;
          p_phase = (p_skip == 16'd0) ? PH_HUNT : PH_SKIP;
        end
      end
      PH_SKIP: begin
        p_skip = p_skip - 16'd1;
        if (p_skip == 16'd0) begin
          p_junk  = 1'b0;
          p_phase = PH_HUNT;
        end
      end
      default: p_phase = PH_IDLE;
    endcase
  endtask

  // Send one input beat after a random gap and track it once accepted
  task automatic send_beat(input logic [7:0] b, input bit sof, input bit eof);
    int gap;
    bit rdy;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    byte_value    <= b;
    start_of_file <= sof;
    end_of_file   <= eof;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    scan_step(b, sof, eof);
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatches < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Result side: random stall per beat, compare against the oldest report
  initial begin
    int stall;
    bit took;
    report_t exp_r;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid && out_ready;
        if (took) begin
          if (pending_reports.size() == 0) begin
            flag_mismatch($sformatf("unexpected result status=%0d h=%0d w=%0d",
                                    status, frame_height, frame_width));
          end else begin
            exp_r = pending_reports.pop_front();
            if (status !== exp_r.status || frame_height !== exp_r.height ||
                frame_width !== exp_r.width)
              flag_mismatch($sformatf("expected status=%0d h=%0d w=%0d, got status=%0d h=%0d w=%0d",
                                      exp_r.status, exp_r.height, exp_r.width,
                                      status, frame_height, frame_width));
          end
        end
        @(posedge clk);
      end while (!took);
    end
  end

  // ---- file builders ----

  function automatic logic [7:0] segment_code();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = MK_NUL;
      1: c = MK_SOI;
      2: c = MK_DHT;
      3: c = MK_JPG;
      4: c = MK_DAC;
      5: c = MK_RST0 | 8'($urandom_range(0, 7));
      default: begin
        do c = 8'($urandom);
        while (c == MK_FILL || c == MK_SOS || c == MK_EOI || sof_code(c));
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] frame_code();
    logic [7:0] c;
    do c = MK_SOF_LO | 8'($urandom_range(0, 15));
    while (!sof_code(c));
    return c;
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // FF, optional fill run, then the marker code
  task automatic add_marker(input logic [7:0] code);
    int fills;
    fills = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (fills + 1) file_q.push_back(MK_FILL);
    file_q.push_back(code);
  endtask

  task automatic build_file(input file_kind_t kind);
    int nseg;
    logic [15:0] len, h, w;
    logic [7:0] c;
    file_q.delete();
    if (kind == FK_BAD_START) begin
      if ($urandom_range(0, 1)) begin
        file_q.push_back(8'($urandom_range(0, 254)));
        file_q.push_back(MK_SOI);
      end else begin
        do c = 8'($urandom);
        while (c == MK_SOI);
        file_q.push_back(MK_FILL);
        file_q.push_back(c);
      end
    end else begin
      file_q.push_back(MK_FILL);
      file_q.push_back(MK_SOI);
    end
    nseg = $urandom_range(0, 3);
    repeat (nseg) begin
      add_marker(segment_code());
      len = 16'($urandom_range(2, 9));
      file_q.push_back(len[15:8]);
      file_q.push_back(len[7:0]);
      repeat (len - 2) file_q.push_back(8'($urandom));
    end
    if (kind == FK_JUNK)
      repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(0, 254)));
    case (kind)
      FK_SCAN_END: add_marker($urandom_range(0, 1) ? MK_SOS : MK_EOI);
      FK_BAD_LEN: begin
        add_marker(segment_code());
        file_q.push_back(8'h00);
        file_q.push_back(8'($urandom_range(0, 1)));
      end
      default: begin
        h = pick_dim();
        w = pick_dim();
        add_marker(frame_code());
        file_q.push_back(8'($urandom));
        file_q.push_back(8'($urandom));
        file_q.push_back(8'($urandom));
        file_q.push_back(h[15:8]);
        file_q.push_back(h[7:0]);
        file_q.push_back(w[15:8]);
        file_q.push_back(w[7:0]);
        file_q.push_back(8'($urandom));
      end
    endcase
  endtask

  // Send the built file, optionally cut short by an end of stream
  task automatic play_file(input bit truncate);
    int stop;
    stop = truncate ? $urandom_range(1, file_q.size() - 1) : file_q.size();
    for (int i = 0; i < stop; i++) send_beat(file_q[i], i == 0, 1'b0);
    if (truncate) send_beat(8'($urandom), 1'b0, 1'b1);
    // bytes after the parse has finished must stay silent
    if ($urandom_range(0, 5) == 0) send_beat(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // ---- tests ----

  // First file right after reset without a start flag, largest size
  task automatic test_no_start_flag();
    logic [7:0] bytes[12] = '{MK_FILL, MK_SOI, MK_FILL, MK_SOF_LO, 8'h00, 8'h08, 8'h08,
                              8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h03};
    foreach (bytes[i]) send_beat(bytes[i], 1'b0, 1'b0);
  endtask

  // Bytes and end of stream after a result give nothing
  task automatic test_finished_parse();
    send_beat(8'h55, 1'b0, 1'b0);
    send_beat(8'hAA, 1'b0, 1'b1);
  endtask

  task automatic test_start_with_end();
    send_beat(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_bad_start();
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(MK_FILL, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
  endtask

  // Junk byte before a fill run, reported on the marker code
  task automatic test_junk_before_marker();
    logic [7:0] bytes[7] = '{MK_FILL, MK_SOI, 8'h00, MK_FILL, MK_FILL, MK_FILL, MK_SOF_LO};
    foreach (bytes[i]) send_beat(bytes[i], i == 0, 1'b0);
  endtask

  // Segment with a length high byte set, then a zero-size frame
  task automatic test_long_segment();
    file_q.delete();
    file_q = '{MK_FILL, MK_SOI, MK_FILL, MK_APP1, 8'h01, 8'h02};
    repeat (16'h0102 - 2) file_q.push_back(8'($urandom));
    file_q = {file_q, MK_FILL, MK_SOF_HI, 8'h00, 8'h11, 8'h08,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
    play_file(1'b0);
  endtask

  task automatic test_random_files(input int beats);
    int target;
    target = parsed_beats + beats;
    while (parsed_beats < target) begin
      build_file(FK_GOOD);
      play_file($urandom_range(0, 5) == 0);
    end
  endtask

  task automatic test_broken_files(input int beats);
    int target;
    target = parsed_beats + beats;
    while (parsed_beats < target) begin
      build_file(file_kind_t'($urandom_range(0, 4)));
      play_file($urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_noise(input int beats);
    int target;
    target = parsed_beats + beats;
    while (parsed_beats < target)
      send_beat(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_no_start_flag();
    test_finished_parse();
    test_start_with_end();
    test_bad_start();
    test_junk_before_marker();
    test_long_segment();
    test_random_files(150);
    test_broken_files(80);
    test_noise(15);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
